// ===== rtl/core/ilkv_pkg.sv =====
// shared types and character codes for the ini line key/value splitter
package ilkv_pkg;

  typedef enum logic [1:0] {
    ST_PAIR  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  localparam int unsigned FIELD_W            = 8;
  localparam int unsigned DEF_LINE_MAX_BYTES = 128;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  typedef struct packed {
    logic too_long;
    logic bad_control_byte;
    logic seen_nonblank;
    logic first_is_hash;
    logic equal_seen;
    logic second_equal_seen;
    logic key_nonempty;
    logic value_started;
  } line_flags_t;

endpackage

// ===== rtl/core/ilkv_if.sv =====
// item channels of the ini line key/value splitter
interface ilkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       byte_present;
  logic       end_of_line;

  modport source (output valid, line_byte, byte_present, end_of_line, input ready);
  modport sink   (input valid, line_byte, byte_present, end_of_line, output ready);
endinterface

interface ilkv_out_if;
  import ilkv_pkg::*;
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [FIELD_W-1:0]   key_pos;
  logic [FIELD_W-1:0]   key_size;
  logic [FIELD_W-1:0]   val_pos;
  logic [FIELD_W-1:0]   val_size;

  modport source (output valid, status, key_pos, key_size, val_pos, val_size,
                  input ready);
  modport sink   (input valid, status, key_pos, key_size, val_pos, val_size,
                  output ready);
endinterface

// ===== rtl/core/ilkv_tracker.sv =====
// running per-line state: byte count, blank trimming and '=' positions
module ilkv_tracker #(
  parameter int unsigned LINE_MAX_BYTES = ilkv_pkg::DEF_LINE_MAX_BYTES,
  parameter int unsigned CNT_W          = $clog2(LINE_MAX_BYTES + 1),
  parameter int unsigned POS_W          = (LINE_MAX_BYTES > 1) ? $clog2(LINE_MAX_BYTES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            line_byte_i,
  input  logic                  byte_present_i,
  input  logic                  end_of_line_i,
  output ilkv_pkg::line_flags_t flags_o,
  output logic [POS_W-1:0]      first_pos_o,
  output logic [POS_W-1:0]      last_pos_o,
  output logic [POS_W-1:0]      key_end_o,
  output logic [POS_W-1:0]      value_start_o
);
  import ilkv_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(LINE_MAX_BYTES);

  logic [CNT_W-1:0] count_q, count_d;
  line_flags_t      flags_q, flags_d;
  logic [POS_W-1:0] first_q, first_d;
  logic [POS_W-1:0] last_q, last_d;
  logic [POS_W-1:0] key_end_q, key_end_d;
  logic [POS_W-1:0] vstart_q, vstart_d;
  logic [POS_W-1:0] pos;
  logic             is_blank;
  logic             is_ctrl;

  assign pos      = count_q[POS_W-1:0];
  assign is_blank = (line_byte_i == CH_SPACE) || (line_byte_i == CH_TAB);
  assign is_ctrl  = (line_byte_i == CH_NUL) || (line_byte_i == CH_CR) ||
                    (line_byte_i == CH_LF);

  always_comb begin
    count_d   = count_q;
    flags_d   = flags_q;
    first_d   = first_q;
    last_d    = last_q;
    key_end_d = key_end_q;
    vstart_d  = vstart_q;
    if (accept_i && byte_present_i) begin
      if (count_q == MaxCnt) begin
        flags_d.too_long = 1'b1;
      end else begin
        count_d = count_q + 1'b1;
        if (is_ctrl) begin
          flags_d.bad_control_byte = 1'b1;
        end
        if (!is_blank) begin
          if (!flags_q.seen_nonblank) begin
            flags_d.seen_nonblank = 1'b1;
            flags_d.first_is_hash = (line_byte_i == CH_HASH);
            first_d               = pos;
          end
          if (line_byte_i == CH_EQUAL) begin
            if (flags_q.equal_seen) begin
              flags_d.second_equal_seen = 1'b1;
            end else begin
              flags_d.equal_seen   = 1'b1;
              flags_d.key_nonempty = (pos != first_d);
              key_end_d            = flags_d.key_nonempty ? last_q + 1'b1 : pos;
            end
          end else if (flags_q.equal_seen && !flags_q.value_started) begin
            flags_d.value_started = 1'b1;
            vstart_d              = pos;
          end
          last_d = pos;
        end
      end
    end
  end

  assign flags_o       = flags_d;
  assign first_pos_o   = first_d;
  assign last_pos_o    = last_d;
  assign key_end_o     = key_end_d;
  assign value_start_o = vstart_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      flags_q   <= '0;
      first_q   <= '0;
      last_q    <= '0;
      key_end_q <= '0;
      vstart_q  <= '0;
    end else if (accept_i && end_of_line_i) begin
      count_q   <= '0;
      flags_q   <= '0;
      first_q   <= '0;
      last_q    <= '0;
      key_end_q <= '0;
      vstart_q  <= '0;
    end else begin
      count_q   <= count_d;
      flags_q   <= flags_d;
      first_q   <= first_d;
      last_q    <= last_d;
      key_end_q <= key_end_d;
      vstart_q  <= vstart_d;
    end
  end

endmodule

// ===== rtl/core/ilkv_verdict.sv =====
// end-of-line verdict and the result register
module ilkv_verdict #(
  parameter int unsigned LINE_MAX_BYTES = ilkv_pkg::DEF_LINE_MAX_BYTES,
  parameter int unsigned CNT_W          = $clog2(LINE_MAX_BYTES + 1),
  parameter int unsigned POS_W          = (LINE_MAX_BYTES > 1) ? $clog2(LINE_MAX_BYTES) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ilkv_pkg::line_flags_t flags_i,
  input  logic [POS_W-1:0]      first_pos_i,
  input  logic [POS_W-1:0]      last_pos_i,
  input  logic [POS_W-1:0]      key_end_i,
  input  logic [POS_W-1:0]      value_start_i,
  output logic                  free_o,
  ilkv_out_if.source            out_o
);
  import ilkv_pkg::*;

  logic               valid_q;
  status_e            status_q, status_d;
  logic [FIELD_W-1:0] ko_q, ko_d;
  logic [FIELD_W-1:0] kl_q, kl_d;
  logic [FIELD_W-1:0] vo_q, vo_d;
  logic [FIELD_W-1:0] vl_q, vl_d;
  logic [POS_W-1:0]   key_len;
  logic [CNT_W-1:0]   val_len;

  assign key_len = key_end_i - first_pos_i;
  assign val_len = CNT_W'(last_pos_i) + 1'b1 - CNT_W'(value_start_i);

  always_comb begin
    status_d = ST_ERROR;
    ko_d     = '0;
    kl_d     = '0;
    vo_d     = '0;
    vl_d     = '0;
    priority if (flags_i.too_long || flags_i.bad_control_byte) begin
      status_d = ST_ERROR;
    end else if (!flags_i.seen_nonblank || flags_i.first_is_hash) begin
      status_d = ST_SKIP;
    end else if (!flags_i.equal_seen || flags_i.second_equal_seen ||
                 !flags_i.key_nonempty || !flags_i.value_started) begin
      status_d = ST_ERROR;
    end else begin
      status_d = ST_PAIR;
      ko_d     = FIELD_W'(first_pos_i);
      kl_d     = FIELD_W'(key_len);
      vo_d     = FIELD_W'(value_start_i);
      vl_d     = FIELD_W'(val_len);
    end
  end

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_d;
      ko_q     <= ko_d;
      kl_q     <= kl_d;
      vo_q     <= vo_d;
      vl_q     <= vl_d;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.status   = status_q;
  assign out_o.key_pos  = ko_q;
  assign out_o.key_size = kl_q;
  assign out_o.val_pos  = vo_q;
  assign out_o.val_size = vl_q;

endmodule

// ===== rtl/core/ini_line_key_value_splitter.sv =====
// top level of the ini line key/value splitter
//
// in_i carries one byte of a text line per item (line_byte, byte_present)
// and end_of_line on the last item of the line. out_o carries one verdict
// per line: status (pair, skip or error) with trimmed key and value offsets
// and lengths, all zero unless status is pair.
// One item is taken per cycle while no end_of_line item waits. The tracker
// updates the per-line state in the cycle of acceptance, and the verdict is
// formed from that updated state and written to the result register, so a
// result is valid in the cycle after its end_of_line item is accepted.
// Bytes beyond LINE_MAX_BYTES are not counted; the line then ends in error.
// While a result waits in the register, items without end_of_line are still
// taken; an end_of_line item waits until the register is taken or empty.
// Reset clears the line state and empties the result register.
module ini_line_key_value_splitter #(
  parameter int unsigned LINE_MAX_BYTES = ilkv_pkg::DEF_LINE_MAX_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ilkv_in_if.sink     in_i,
  ilkv_out_if.source  out_o
);
  import ilkv_pkg::*;

  localparam int unsigned CntW = $clog2(LINE_MAX_BYTES + 1);
  localparam int unsigned PosW = (LINE_MAX_BYTES > 1) ? $clog2(LINE_MAX_BYTES) : 1;

  logic             accept;
  logic             free;
  line_flags_t      flags;
  logic [PosW-1:0]  first_pos;
  logic [PosW-1:0]  last_pos;
  logic [PosW-1:0]  key_end;
  logic [PosW-1:0]  value_start;

  assign in_i.ready = free || !in_i.end_of_line;
  assign accept     = in_i.valid && in_i.ready;

  ilkv_tracker #(
    .LINE_MAX_BYTES (LINE_MAX_BYTES),
    .CNT_W          (CntW),
    .POS_W          (PosW)
  ) u_tracker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .line_byte_i    (in_i.line_byte),
    .byte_present_i (in_i.byte_present),
    .end_of_line_i  (in_i.end_of_line),
    .flags_o        (flags),
    .first_pos_o    (first_pos),
    .last_pos_o     (last_pos),
    .key_end_o      (key_end),
    .value_start_o  (value_start)
  );

  ilkv_verdict #(
    .LINE_MAX_BYTES (LINE_MAX_BYTES),
    .CNT_W          (CntW),
    .POS_W          (PosW)
  ) u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && in_i.end_of_line),
    .flags_i       (flags),
    .first_pos_i   (first_pos),
    .last_pos_i    (last_pos),
    .key_end_i     (key_end),
    .value_start_i (value_start),
    .free_o        (free),
    .out_o         (out_o)
  );

  a_eol_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.end_of_line |=> out_o.valid)
    else $error("end of line item gave no result");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid && !out_o.ready)
    else $error("input stalled without a pending result");

  a_no_pair_no_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status != ST_PAIR |->
      out_o.key_pos == '0 && out_o.key_size == '0 &&
      out_o.val_pos == '0 && out_o.val_size == '0)
    else $error("offsets set on a skip or error verdict");

  a_line_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.end_of_line |=> !u_tracker.flags_q.seen_nonblank &&
      !u_tracker.flags_q.too_long)
    else $error("line state not cleared after verdict");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the ini line key/value splitter
module testbench;
  import ilkv_pkg::*;

  localparam int unsigned LINE_MAX    = DEF_LINE_MAX_BYTES;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_ITEMS = 100;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    status_e    status;
    logic [7:0] key_pos;
    logic [7:0] key_size;
    logic [7:0] val_pos;
    logic [7:0] val_size;
  } verdict_t;

  logic clk;
  logic rst_n;

  ilkv_in_if  in_if();
  ilkv_out_if out_if();

  ini_line_key_value_splitter #(
    .LINE_MAX_BYTES(LINE_MAX)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  verdict_t expected_verdicts[$];
  int       mismatches;
  int       cycle_count;
  int       items_sent;
  int       burst_left;
  int       ready_mode;
  int       ready_tick;

  // running state of the line being predicted
  int unsigned line_count;
  bit          line_too_long;
  bit          line_ctrl;
  bit          line_seen;
  int unsigned line_first;
  bit          line_hash;
  int unsigned line_last;
  bit          line_eq;
  bit          line_eq2;
  int unsigned line_key_end;
  bit          line_key_ok;
  int unsigned line_val_start;
  bit          line_val_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_line_state();
    line_count     = 0;
    line_too_long  = 0;
    line_ctrl      = 0;
    line_seen      = 0;
    line_first     = 0;
    line_hash      = 0;
    line_last      = 0;
    line_eq        = 0;
    line_eq2       = 0;
    line_key_end   = 0;
    line_key_ok    = 0;
    line_val_start = 0;
    line_val_seen  = 0;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    int unsigned pos;
    if (line_count >= LINE_MAX) begin
      line_too_long = 1;
      return;
    end
    pos = line_count;
    line_count++;
    if (b == CH_NUL || b == CH_CR || b == CH_LF) line_ctrl = 1;
    if (b == CH_SPACE || b == CH_TAB) return;
    if (!line_seen) begin
      line_seen  = 1;
      line_first = pos;
      line_hash  = (b == CH_HASH);
    end
    if (b == CH_EQUAL) begin
      if (line_eq) begin
        line_eq2 = 1;
      end else begin
        line_eq      = 1;
        line_key_ok  = (pos != line_first);
        line_key_end = line_key_ok ? line_last + 1 : pos;
      end
    end else if (line_eq && !line_val_seen) begin
      line_val_seen  = 1;
      line_val_start = pos;
    end
    line_last = pos;
  endfunction

  function automatic void predict_verdict(logic [7:0] b, logic present, logic eol);
    verdict_t v;
    if (present) absorb_byte(b);
    if (!eol) return;
    v.status   = ST_ERROR;
    v.key_pos  = '0;
    v.key_size = '0;
    v.val_pos  = '0;
    v.val_size = '0;
    if (line_too_long || line_ctrl) begin
      v.status = ST_ERROR;
    end else if (!line_seen || line_hash) begin
      v.status = ST_SKIP;
    end else if (!line_eq || line_eq2 || !line_key_ok || !line_val_seen) begin
      v.status = ST_ERROR;
    end else begin
      v.status   = ST_PAIR;
      v.key_pos  = 8'(line_first);
      v.key_size = 8'(line_key_end - line_first);
      v.val_pos  = 8'(line_val_start);
      v.val_size = 8'(line_last + 1 - line_val_start);
    end
    expected_verdicts.push_back(v);
    clear_line_state();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(logic [7:0] b, logic present, logic eol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_if.valid        <= 1'b1;
    in_if.line_byte    <= b;
    in_if.byte_present <= present;
    in_if.end_of_line  <= eol;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
    if (present || eol) items_sent++;
    predict_verdict(b, present, eol);
  endtask

  task automatic send_line(byte_q_t bytes, bit eol_alone);
    for (int i = 0; i < bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(bytes[i], 1'b1, !eol_alone && i == bytes.size() - 1);
    end
    if (eol_alone || bytes.size() == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic byte_q_t text(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic byte_q_t fill(logic [7:0] b, int n);
    byte_q_t q;
    repeat (n) q.push_back(b);
    return q;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) != 0) ? CH_SPACE : CH_TAB;
  endfunction

  // any byte that is neither blank, control, '=' nor '#'
  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'hFF));
    while (c == CH_EQUAL || c == CH_HASH);
    return c;
  endfunction

  function automatic void add_blanks(ref byte_q_t q, input int max_n);
    repeat ($urandom_range(0, max_n)) q.push_back(blank_char());
  endfunction

  function automatic void add_word(ref byte_q_t q, input int min_n, input int max_n,
                                   input bit hash_ok);
    int n;
    n = $urandom_range(min_n, max_n);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && i < n - 1 && $urandom_range(0, 5) == 0) q.push_back(blank_char());
      else if (hash_ok && i > 0 && $urandom_range(0, 9) == 0) q.push_back(CH_HASH);
      else q.push_back(word_char());
    end
  endfunction

  function automatic byte_q_t random_line();
    byte_q_t q;
    int      kind;
    int      n;
    logic [7:0] ctrl;
    kind = $urandom_range(0, 99);
    if (kind < 60 || (kind >= 75 && kind < 92)) begin
      add_blanks(q, 3);
      if (!(kind >= 80 && kind < 83)) add_word(q, 1, 6, 1);
      add_blanks(q, 2);
      q.push_back(CH_EQUAL);
      add_blanks(q, 2);
      if (!(kind >= 83 && kind < 85)) add_word(q, 1, 8, 1);
      if (kind >= 75 && kind < 80) begin
        q.insert($urandom_range(0, q.size()), CH_EQUAL);
      end
      add_blanks(q, 3);
      if (kind >= 85) begin
        case ($urandom_range(0, 2))
          0: ctrl = CH_NUL;
          1: ctrl = CH_CR;
          default: ctrl = CH_LF;
        endcase
        q.insert($urandom_range(0, q.size()), ctrl);
      end
    end else if (kind < 65) begin
      add_blanks(q, 2);
      q.push_back(CH_HASH);
      add_word(q, 0, 6, 1);
      if ($urandom_range(0, 1) != 0) q.push_back(CH_EQUAL);
    end else if (kind < 70) begin
      add_blanks(q, 4);
    end else if (kind < 75) begin
      add_blanks(q, 2);
      add_word(q, 1, 8, 1);
      add_blanks(q, 2);
    end else if (kind < 97) begin
      n = $urandom_range(0, 10);
      repeat (n) q.push_back(8'($urandom));
    end else begin
      q.push_back(word_char());
      q.push_back(CH_EQUAL);
      n = $urandom_range(LINE_MAX - 4, LINE_MAX + 3);
      repeat (n) q.push_back(($urandom_range(0, 7) == 0) ? blank_char() : word_char());
    end
    return q;
  endfunction

  task automatic test_pairs();
    send_line(text("a=b"), 0);
    send_line(text(" \tkey \t=\t value  \t"), 1);
    send_line(text("a b = c d"), 0);
    send_line(text("k#=v#"), 0);
    send_line({8'hFF, CH_EQUAL, 8'h80}, 0);
    send_line({text("k="), fill(8'h76, LINE_MAX - 2)}, 0);
    send_line({text("k="), fill(8'h76, LINE_MAX - 2)}, 1);
  endtask

  task automatic test_skips();
    send_line(text(""), 1);
    send_line(text(" \t \t"), 0);
    send_line(text("# a=b"), 0);
    send_line(text("  #"), 1);
  endtask

  task automatic test_errors();
    send_line(text("abc"), 0);
    send_line(text("a=b=c"), 0);
    send_line(text(" = b"), 0);
    send_line(text("a= \t"), 0);
    send_line(text("="), 1);
    send_line({text("a="), CH_NUL, text("b")}, 0);
    send_line({text("a=b"), CH_CR}, 0);
    send_line({CH_HASH, CH_LF}, 0);
    send_line({text("k="), fill(8'h76, LINE_MAX - 1)}, 0);
    send_line(fill(CH_SPACE, LINE_MAX + 2), 1);
  endtask

  task automatic test_ignored_items();
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_line(text("x=y"), 1);
    send_item(CH_EQUAL, 1'b0, 1'b0);
    send_item(CH_HASH, 1'b0, 1'b1);
  endtask

  task automatic test_random_lines(int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      send_line(random_line(), $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
    end
  endtask

  always @(posedge clk) begin
    ready_tick++;
    if (ready_tick % 50 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(0, 1) != 0);
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= (ready_tick % 8 == 0);
    endcase
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected verdict, status", out_if.status, -1);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_if.status !== want.status)
          report_mismatch("status", out_if.status, want.status);
        if (out_if.key_pos !== want.key_pos)
          report_mismatch("key_pos", out_if.key_pos, want.key_pos);
        if (out_if.key_size !== want.key_size)
          report_mismatch("key_size", out_if.key_size, want.key_size);
        if (out_if.val_pos !== want.val_pos)
          report_mismatch("val_pos", out_if.val_pos, want.val_pos);
        if (out_if.val_size !== want.val_size)
          report_mismatch("val_size", out_if.val_size, want.val_size);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ini_line_key_value_splitter verification failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.line_byte    = '0;
    in_if.byte_present = 1'b0;
    in_if.end_of_line  = 1'b0;
    out_if.ready       = 1'b0;
    mismatches         = 0;
    cycle_count        = 0;
    items_sent         = 0;
    burst_left         = 0;
    ready_mode         = 0;
    ready_tick         = 0;
    clear_line_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pairs();
    test_skips();
    test_errors();
    test_ignored_items();
    test_random_lines(RANDOM_ITEMS);

    in_if.valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("ini_line_key_value_splitter verification clean");
    end else begin
      $display("ini_line_key_value_splitter verification failed");
    end
    $finish;
  end

endmodule

// ===== ini_line_key_value_splitter.f =====
rtl/core/ilkv_pkg.sv
rtl/core/ilkv_if.sv
rtl/core/ilkv_tracker.sv
rtl/core/ilkv_verdict.sv
rtl/core/ini_line_key_value_splitter.sv
dv/testbench.sv
